// File: rtl/tbim_pkg.sv
// Package for the two-body invariant mass block.
// Holds field widths, the transfer payload structs and the square-root cell data type.
// No dependencies.
package tbim_pkg;

  localparam int MassBits     = 18;
  localparam int MomentumBits = 20;
  localparam int PairMassBits = 21;

  // Radicand width and root width common to all square-root cells. The radicand must
  // hold the squared energy sum, which is bounded by the wider of the mass and
  // momentum terms.
  localparam int RadBits  = (MassBits + 1 > MomentumBits) ? 2 * MassBits + 4
                                                          : 2 * MomentumBits + 2;
  localparam int RootBits = RadBits / 2;
  localparam int RemBits  = RootBits + 2;
  localparam int AuxBits  = RadBits + 1;

  typedef struct packed {
    logic [MassBits-1:0]            mass_a;
    logic signed [MomentumBits-1:0] px_a;
    logic signed [MomentumBits-1:0] py_a;
    logic signed [MomentumBits-1:0] pz_a;
    logic [MassBits-1:0]            mass_b;
    logic signed [MomentumBits-1:0] px_b;
    logic signed [MomentumBits-1:0] py_b;
    logic signed [MomentumBits-1:0] pz_b;
  } item_t;

  typedef struct packed {
    logic [PairMassBits-1:0] pair_mass;
    logic                    clamped;
  } result_t;

  typedef struct packed {
    logic                vld;
    logic [RadBits-1:0]  x;
    logic [RemBits-1:0]  rem;
    logic [RootBits-1:0] root;
    logic [AuxBits-1:0]  aux;
  } sqc_t;

endpackage

// File: rtl/tbim_sqrt_cell.sv
// One digit step of the floor integer square root.
// Uses tbim_pkg for the cell data type.
module tbim_sqrt_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  tbim_pkg::sqc_t din,
  output tbim_pkg::sqc_t dout
);

  logic [tbim_pkg::RemBits+1:0] t;
  logic [tbim_pkg::RemBits+1:0] trial;
  logic [tbim_pkg::RemBits+1:0] diff;
  logic                         ge;

  assign t     = {din.rem, din.x[tbim_pkg::RadBits-1 -: 2]};
  assign trial = {2'b00, din.root, 2'b01};
  assign ge    = (t >= trial);
  assign diff  = t - trial;

  // Only the valid bit is reset; the payload just moves with the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else if (en) begin
      dout.vld <= din.vld;
    end
    if (en) begin
      dout.x    <= {din.x[tbim_pkg::RadBits-3:0], 2'b00};
      dout.rem  <= ge ? diff[tbim_pkg::RemBits-1:0] : t[tbim_pkg::RemBits-1:0];
      dout.root <= {din.root[tbim_pkg::RootBits-2:0], ge};
      dout.aux  <= din.aux;
    end
  end

endmodule

// File: rtl/tbim_isqrt.sv
// Chain of square-root cells, one root bit per cell.
// Uses tbim_pkg and tbim_sqrt_cell.
module tbim_isqrt (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  tbim_pkg::sqc_t din,
  output tbim_pkg::sqc_t dout
);

  tbim_pkg::sqc_t link [tbim_pkg::RootBits+1];

  assign link[0] = din;

  for (genvar i = 0; i < tbim_pkg::RootBits; i++) begin : g_cell
    tbim_sqrt_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .din  (link[i]),
      .dout (link[i+1])
    );
  end

  assign dout = link[tbim_pkg::RootBits];

endmodule

// File: rtl/two_body_invariant_mass.sv
// Two-body invariant mass: pipeline with three chains of square-root cells.
// Accepts one item per cycle while no valid result is stalled at the output.
// An item passes three arithmetic stages and two square-root chains of 21 cells each in series.
// A stalled valid result holds the whole pipeline; input stall follows that output stall.
// Reset (synchronous, active high) clears every valid bit; no result is pending after it.
// Uses tbim_pkg and tbim_isqrt.
module two_body_invariant_mass (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  tbim_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output tbim_pkg::result_t result
);

  localparam int MomSumBits = tbim_pkg::MomentumBits + 1;
  localparam int SqBits     = 2 * tbim_pkg::MomentumBits;
  localparam int SumSqBits  = 2 * MomSumBits;

  // The whole pipeline advances unless the result register is full and stalled.
  logic en;
  tbim_pkg::sqc_t chain_c_out;

  assign en         = !(chain_c_out.vld && result_stall);
  assign item_stall = !en;

  // Stage 1: individual squares and the summed momentum components.
  logic                         v1;
  logic [2*tbim_pkg::MassBits-1:0] ma2, mb2;
  logic signed [SqBits-1:0]     xa2, ya2, za2, xb2, yb2, zb2;
  logic signed [MomSumBits-1:0] sx, sy, sz;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma2 <= item.mass_a * item.mass_a;
      mb2 <= item.mass_b * item.mass_b;
      xa2 <= item.px_a * item.px_a;
      ya2 <= item.py_a * item.py_a;
      za2 <= item.pz_a * item.pz_a;
      xb2 <= item.px_b * item.px_b;
      yb2 <= item.py_b * item.py_b;
      zb2 <= item.pz_b * item.pz_b;
      sx  <= MomSumBits'(item.px_a) + MomSumBits'(item.px_b);
      sy  <= MomSumBits'(item.py_a) + MomSumBits'(item.py_b);
      sz  <= MomSumBits'(item.pz_a) + MomSumBits'(item.pz_b);
    end
  end

  // Stage 2: squared energies and squares of the summed momentum.
  logic                        v2;
  logic [tbim_pkg::RadBits-1:0] ea2, eb2;
  logic signed [SumSqBits-1:0] sx2, sy2, sz2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ea2 <= tbim_pkg::RadBits'(ma2) + tbim_pkg::RadBits'(unsigned'(xa2))
           + tbim_pkg::RadBits'(unsigned'(ya2)) + tbim_pkg::RadBits'(unsigned'(za2));
      eb2 <= tbim_pkg::RadBits'(mb2) + tbim_pkg::RadBits'(unsigned'(xb2))
           + tbim_pkg::RadBits'(unsigned'(yb2)) + tbim_pkg::RadBits'(unsigned'(zb2));
      sx2 <= sx * sx;
      sy2 <= sy * sy;
      sz2 <= sz * sz;
    end
  end

  // Energy square roots. Chain A carries the squared summed momentum alongside.
  tbim_pkg::sqc_t chain_a_in, chain_b_in, chain_a_out, chain_b_out;
  logic [tbim_pkg::RadBits-1:0] p2;

  assign p2 = tbim_pkg::RadBits'(unsigned'(sx2)) + tbim_pkg::RadBits'(unsigned'(sy2))
            + tbim_pkg::RadBits'(unsigned'(sz2));

  always_comb begin
    chain_a_in      = '0;
    chain_a_in.vld  = v2;
    chain_a_in.x    = ea2;
    chain_a_in.aux  = {1'b0, p2};
    chain_b_in      = '0;
    chain_b_in.vld  = v2;
    chain_b_in.x    = eb2;
  end

  tbim_isqrt u_energy_a (
    .clk (clk), .rst (rst), .en (en), .din (chain_a_in), .dout (chain_a_out)
  );

  tbim_isqrt u_energy_b (
    .clk (clk), .rst (rst), .en (en), .din (chain_b_in), .dout (chain_b_out)
  );

  // Stage 4: squared energy sum. Each energy is below 2^20, so the sum fits the root width.
  logic                         v4;
  logic [tbim_pkg::RootBits-1:0] es;
  logic [tbim_pkg::RadBits-1:0]  e2, p2_d;

  assign es = chain_a_out.root + chain_b_out.root;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= chain_a_out.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e2   <= es * es;
      p2_d <= chain_a_out.aux[tbim_pkg::RadBits-1:0];
    end
  end

  // Squared mass, clamped to zero when flooring made it negative; the flag rides as aux.
  tbim_pkg::sqc_t chain_c_in;
  logic           neg;

  assign neg = (e2 < p2_d);

  always_comb begin
    chain_c_in     = '0;
    chain_c_in.vld = v4;
    chain_c_in.x   = neg ? '0 : (e2 - p2_d);
    chain_c_in.aux = tbim_pkg::AuxBits'(neg);
  end

  tbim_isqrt u_pair_mass (
    .clk (clk), .rst (rst), .en (en), .din (chain_c_in), .dout (chain_c_out)
  );

  // The last cell of the chain is the output register.
  assign result_valid     = chain_c_out.vld;
  assign result.pair_mass = tbim_pkg::PairMassBits'(chain_c_out.root);
  assign result.clamped   = chain_c_out.aux[0];

endmodule

// File: rtl/tbim_checker.sv
// Port-level checks for two_body_invariant_mass, bound to the top level.
// Uses tbim_pkg for the payload types.
module tbim_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_stall,
  input logic              result_valid,
  input logic              result_stall,
  input tbim_pkg::result_t result
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid && result_stall)
    else $error("input stalled without a stalled result");

  a_clamp_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.clamped |-> result.pair_mass == '0)
    else $error("clamped result has nonzero mass");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind two_body_invariant_mass tbim_checker u_tbim_checker (
  .clk          (clk),
  .rst          (rst),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

// File: tb/testbench.sv
// Testbench for the two-body invariant mass pipeline.
// Drives particle pairs, predicts pair mass and the clamp flag, and checks each transfer.
// Depends on tbim_pkg and two_body_invariant_mass.
module testbench;

  logic              clk;
  logic              rst;
  logic              item_valid;
  logic              item_stall;
  tbim_pkg::item_t   item;
  logic              result_valid;
  logic              result_stall;
  tbim_pkg::result_t result;

  // Expected results, oldest first, and the running error count.
  tbim_pkg::result_t pending_masses[$];
  int                error_count;

  // Idle control for both sides. A zero rate gives a stretch with no gaps.
  int      send_idle_pct;
  int      recv_idle_pct;
  // A long receiver hold is requested by bumping hold_requests; the receiver
  // process counts the stretch itself.
  int      hold_requests;
  int      hold_served;
  int      hold_cycles;

  two_body_invariant_mass i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Floor square root by bitwise restoring method on an unsigned 64-bit value.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] root;
    logic [63:0] bitpos;
    root   = '0;
    bitpos = 64'd1 << 62;
    while (bitpos > n) bitpos = bitpos >> 2;
    while (bitpos != 0) begin
      if (n >= root + bitpos) begin
        n    = n - (root + bitpos);
        root = (root >> 1) + bitpos;
      end else begin
        root = root >> 1;
      end
      bitpos = bitpos >> 2;
    end
    return root;
  endfunction

  function automatic logic [63:0] particle_energy(input logic [tbim_pkg::MassBits-1:0] m,
      input logic signed [tbim_pkg::MomentumBits-1:0] x,
      input logic signed [tbim_pkg::MomentumBits-1:0] y,
      input logic signed [tbim_pkg::MomentumBits-1:0] z);
    longint sx, sy, sz, mm;
    mm = longint'(m);
    sx = longint'(x);
    sy = longint'(y);
    sz = longint'(z);
    return floor_sqrt(mm * mm + sx * sx + sy * sy + sz * sz);
  endfunction

  // Pair invariant mass; the squared mass is clamped to zero when energy
  // flooring makes it negative.
  function automatic tbim_pkg::result_t pair_invariant_mass(input tbim_pkg::item_t p);
    tbim_pkg::result_t r;
    logic [63:0]       esum, e2, p2;
    longint            sx, sy, sz;
    esum = particle_energy(p.mass_a, p.px_a, p.py_a, p.pz_a)
         + particle_energy(p.mass_b, p.px_b, p.py_b, p.pz_b);
    sx = longint'(p.px_a) + longint'(p.px_b);
    sy = longint'(p.py_a) + longint'(p.py_b);
    sz = longint'(p.pz_a) + longint'(p.pz_b);
    e2 = esum * esum;
    p2 = sx * sx + sy * sy + sz * sz;
    if (e2 >= p2) begin
      r.pair_mass = tbim_pkg::PairMassBits'(floor_sqrt(e2 - p2));
      r.clamped   = 1'b0;
    end else begin
      r.pair_mass = '0;
      r.clamped   = 1'b1;
    end
    return r;
  endfunction

  // Offers one pair, with a random idle gap first, and waits for its transfer.
  // The expectation is queued at the accepting edge. Valid stays high after the
  // transfer so that the next pair can follow directly; wait_drained drops it.
  task automatic send_pair(input tbim_pkg::item_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= p;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    pending_masses.push_back(pair_invariant_mass(p));
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (pending_masses.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [tbim_pkg::MomentumBits-1:0] rand_momentum();
    case ($urandom_range(4))
      0: return tbim_pkg::MomentumBits'($urandom_range(255));
      1: return tbim_pkg::MomentumBits'(-$signed({1'b0, 9'($urandom_range(511))}));
      default: return tbim_pkg::MomentumBits'($urandom);
    endcase
  endfunction

  function automatic tbim_pkg::item_t rand_pair();
    tbim_pkg::item_t p;
    p.mass_a = ($urandom_range(3) == 0) ? tbim_pkg::MassBits'($urandom_range(1000))
                                        : tbim_pkg::MassBits'($urandom);
    p.mass_b = ($urandom_range(3) == 0) ? tbim_pkg::MassBits'($urandom_range(1000))
                                        : tbim_pkg::MassBits'($urandom);
    p.px_a = rand_momentum();
    p.py_a = rand_momentum();
    p.pz_a = rand_momentum();
    // Sometimes make the second particle mirror the first, so the summed
    // momentum is small and rounding of the energies matters.
    if ($urandom_range(3) == 0) begin
      p.px_b = tbim_pkg::MomentumBits'(-p.px_a
             + $signed(tbim_pkg::MomentumBits'($urandom_range(4))) - 2);
      p.py_b = -p.py_a;
      p.pz_b = -p.pz_a;
    end else begin
      p.px_b = rand_momentum();
      p.py_b = rand_momentum();
      p.pz_b = rand_momentum();
    end
    return p;
  endfunction

  // Corner values of every field: zero, the largest mass, both momentum
  // extremes, massless collinear pairs that can go below zero after flooring,
  // and a pair at rest whose squared mass is exactly zero.
  task automatic test_corners();
    tbim_pkg::item_t p;
    logic signed [tbim_pkg::MomentumBits-1:0] pmax, pmin;
    pmax = {1'b0, {(tbim_pkg::MomentumBits-1){1'b1}}};
    pmin = {1'b1, {(tbim_pkg::MomentumBits-1){1'b0}}};
    p = '0;
    send_pair(p);
    p = '{mass_a: '1, px_a: pmax, py_a: pmax, pz_a: pmax,
          mass_b: '1, px_b: pmin, py_b: pmin, pz_b: pmin};
    send_pair(p);
    p = '{mass_a: '1, px_a: pmin, py_a: pmin, pz_a: pmin,
          mass_b: '1, px_b: pmin, py_b: pmin, pz_b: pmin};
    send_pair(p);
    p = '{mass_a: '1, px_a: pmax, py_a: pmax, pz_a: pmax,
          mass_b: '1, px_b: pmax, py_b: pmax, pz_b: pmax};
    send_pair(p);
    p = '{mass_a: 0, px_a: 1, py_a: 1, pz_a: 0, mass_b: 0, px_b: 1, py_b: 1, pz_b: 0};
    send_pair(p);
    p = '{mass_a: 0, px_a: 3, py_a: 5, pz_a: 7, mass_b: 0, px_b: 6, py_b: 10, pz_b: 14};
    send_pair(p);
    p = '{mass_a: 0, px_a: -1, py_a: -2, pz_a: -2, mass_b: 0, px_b: -2, py_b: -4, pz_b: -4};
    send_pair(p);
    p = '{mass_a: 0, px_a: 1000, py_a: 0, pz_a: 0, mass_b: 0, px_b: 1, py_b: 0, pz_b: 0};
    send_pair(p);
    p = '{mass_a: 12345, px_a: 0, py_a: 0, pz_a: 0, mass_b: 0, px_b: 0, py_b: 0, pz_b: 0};
    send_pair(p);
    p = '{mass_a: 0, px_a: 0, py_a: 0, pz_a: pmin, mass_b: 0, px_b: 0, py_b: 0, pz_b: pmin};
    send_pair(p);
    p = '{mass_a: 0, px_a: pmax, py_a: 0, pz_a: 0, mass_b: 0, px_b: pmin, py_b: 0, pz_b: 0};
    send_pair(p);
    p = '{mass_a: 1, px_a: 0, py_a: 0, pz_a: 0, mass_b: 1, px_b: 0, py_b: 0, pz_b: 0};
    send_pair(p);
    // Walk a single set bit through the masses and momenta (pz_b gets its negation) so each bit takes both values.
    for (int b = 0; b < tbim_pkg::MomentumBits; b++) begin
      p = '0;
      p.px_a = tbim_pkg::MomentumBits'(1 <<< b);
      p.py_a = tbim_pkg::MomentumBits'(1 <<< b);
      p.pz_a = tbim_pkg::MomentumBits'(1 <<< b);
      p.px_b = tbim_pkg::MomentumBits'(1 <<< b);
      p.py_b = tbim_pkg::MomentumBits'(1 <<< b);
      p.pz_b = tbim_pkg::MomentumBits'(-(1 <<< b));
      if (b < tbim_pkg::MassBits) begin
        p.mass_a = tbim_pkg::MassBits'(1 << b);
        p.mass_b = tbim_pkg::MassBits'(1 << b);
      end
      send_pair(p);
    end
    wait_drained();
  endtask

  task automatic test_random_stream(input int count);
    for (int n = 0; n < count; n++) send_pair(rand_pair());
  endtask

  // The receiver holds off for a long stretch while items keep coming, so
  // the pipeline fills and stalls its input.
  task automatic test_backpressure();
    hold_requests = hold_requests + 1;
    test_random_stream(120);
    wait_drained();
  endtask

  // Sender pauses until every expected result has come, then resumes.
  task automatic test_drain_pause();
    test_random_stream(40);
    wait_drained();
    test_random_stream(40);
    wait_drained();
  endtask

  // Receiver side: stall at random, or for a counted stretch on request.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      hold_cycles  <= 0;
      hold_served  <= 0;
    end else if (hold_requests != hold_served) begin
      result_stall <= 1'b1;
      hold_served  <= hold_requests;
      hold_cycles  <= 199;
    end else if (hold_cycles > 0) begin
      result_stall <= 1'b1;
      hold_cycles  <= hold_cycles - 1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Each transfer is compared with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_masses.size() == 0) begin
        $display("%0t: unexpected result pair_mass=%0d clamped=%0b",
                 $time, result.pair_mass, result.clamped);
        error_count++;
      end else begin
        tbim_pkg::result_t want;
        want = pending_masses.pop_front();
        if (result.pair_mass !== want.pair_mass) begin
          $display("%0t: pair_mass expected %0d actual %0d",
                   $time, want.pair_mass, result.pair_mass);
          error_count++;
        end
        if (result.clamped !== want.clamped) begin
          $display("%0t: clamped expected %0b actual %0b",
                   $time, want.clamped, result.clamped);
          error_count++;
        end
      end
    end
  end

  initial begin
    rst           = 1'b1;
    item_valid    = 1'b0;
    item          = '0;
    hold_requests = 0;
    send_idle_pct = 26;
    recv_idle_pct = 26;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_corners();
    test_backpressure();
    test_drain_pause();
    test_random_stream(600);
    // A long stretch with no idling on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_stream(400);
    send_idle_pct = 26;
    recv_idle_pct = 26;
    test_random_stream(250);

    wait_drained();
    repeat (60) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
